>>> rtl/core/bpc_pkg.sv
// Shared types and constants for the blue pixel centroid unit.
`default_nettype none

package bpc_pkg;

    localparam int PixW     = 8;
    localparam int CoordW   = 10;
    localparam int CountW   = 21;
    localparam int SumW     = 30;
    localparam int OffW     = 15;
    localparam int QuotW    = 14;
    localparam int DivSteps = 14;
    localparam int StepW    = 4;
    localparam int QDepth   = 4;
    localparam int QPtrW    = 2;
    localparam int InDataW  = 48;
    localparam int OutDataW = 80;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 10;

    localparam logic [CfgIdxW-1:0] CFG_THRESHOLD  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_CENTER_COL = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_CENTER_ROW = 2'd2;

    localparam logic [PixW-1:0]   ThresholdReset = 8'd10;
    localparam logic [CoordW-1:0] CenterColReset = 10'd320;
    localparam logic [CoordW-1:0] CenterRowReset = 10'd120;

    typedef struct packed {
        logic                en;
        logic [CfgIdxW-1:0]  idx;
        logic [CfgDataW-1:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic [PixW-1:0]   blue;
        logic [PixW-1:0]   green;
        logic [PixW-1:0]   red;
        logic              detected;
        logic              last;
        logic [CountW-1:0] count;
        logic [SumW-1:0]   col_sum;
        logic [SumW-1:0]   row_sum;
    } q_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_FIN  = 3'b100
    } back_state_t;

endpackage

`default_nettype wire

>>> rtl/core/bpc_front.sv
// Front end: ratio test, pixel painting and per-frame accumulation.
`default_nettype none

module bpc_front import bpc_pkg::*; #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cfg_wr_t             cfg,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [InDataW-1:0]  s_tdata,
    input  wire logic                s_tlast,
    input  wire logic                q_full,
    output logic                     q_push,
    output q_entry_t                 q_entry
);

    localparam longint Area   = longint'(MAX_COLS) * longint'(MAX_ROWS);
    localparam longint HitCap = (Area < 64'd1048576) ? Area : 64'd1048576;
    localparam logic [CountW-1:0] HitCapC = CountW'(HitCap);
    localparam logic [CoordW-1:0] ColMaxC = CoordW'(MAX_COLS - 1);
    localparam logic [CoordW-1:0] RowMaxC = CoordW'(MAX_ROWS - 1);

    logic [PixW-1:0]   thr_reg;
    logic [CountW-1:0] cnt_reg, cnt_next;
    logic [SumW-1:0]   col_sum_reg, col_sum_next;
    logic [SumW-1:0]   row_sum_reg, row_sum_next;

    logic [PixW-1:0]   blue, green, red;
    logic [CoordW-1:0] col, row, col_c, row_c;
    logic [PixW:0]     lhs, thr1;
    logic [9:0]        den;
    logic [18:0]       prod;
    logic              hit, add;
    logic              accept;

    assign blue  = s_tdata[7:0];
    assign green = s_tdata[15:8];
    assign red   = s_tdata[23:16];
    assign col   = s_tdata[33:24];
    assign row   = s_tdata[43:34];

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign q_push   = accept;

    // floor(x/d) > t  <=>  x >= (t+1)*d
    always_comb begin
        lhs   = {1'b0, blue} + 9'd1;
        thr1  = {1'b0, thr_reg} + 9'd1;
        den   = {2'b0, red} + {2'b0, green} + 10'd2;
        prod  = 19'(thr1) * 19'(den);
        hit   = 19'(lhs) >= prod;
        col_c = (32'(col) >= MAX_COLS) ? ColMaxC : col;
        row_c = (32'(row) >= MAX_ROWS) ? RowMaxC : row;
        add   = hit && (cnt_reg < HitCapC);
        cnt_next     = add ? cnt_reg + CountW'(1) : cnt_reg;
        col_sum_next = add ? col_sum_reg + SumW'(col_c) : col_sum_reg;
        row_sum_next = add ? row_sum_reg + SumW'(row_c) : row_sum_reg;

        q_entry.blue     = hit ? '0 : blue;
        q_entry.green    = hit ? '0 : green;
        q_entry.red      = hit ? '1 : red;
        q_entry.detected = hit;
        q_entry.last     = s_tlast;
        q_entry.count    = cnt_next;
        q_entry.col_sum  = col_sum_next;
        q_entry.row_sum  = row_sum_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg     <= ThresholdReset;
            cnt_reg     <= '0;
            col_sum_reg <= '0;
            row_sum_reg <= '0;
        end else begin
            if (cfg.en && cfg.idx == CFG_THRESHOLD) begin
                thr_reg <= cfg.data[PixW-1:0];
            end
            if (accept) begin
                if (s_tlast) begin
                    cnt_reg     <= '0;
                    col_sum_reg <= '0;
                    row_sum_reg <= '0;
                end else begin
                    cnt_reg     <= cnt_next;
                    col_sum_reg <= col_sum_next;
                    row_sum_reg <= row_sum_next;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/bpc_queue.sv
// Small request queue between front and back end.
`default_nettype none

module bpc_queue import bpc_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wire q_entry_t push_entry,
    input  wire logic     pop,
    output logic          full,
    output logic          empty,
    output q_entry_t      head
);

    q_entry_t         mem_reg [QDepth];
    logic [QPtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPtrW:0]   fill_reg;
    logic             do_pop;

    assign full   = fill_reg == (QPtrW+1)'(QDepth);
    assign empty  = fill_reg == '0;
    assign head   = mem_reg[rd_ptr_reg];
    assign do_pop = pop && !empty;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPtrW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPtrW'(1);
            end
            if (push && !do_pop) begin
                fill_reg <= fill_reg + (QPtrW+1)'(1);
            end else if (!push && do_pop) begin
                fill_reg <= fill_reg - (QPtrW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/bpc_back.sv
// Back end: centroid division at frame end and the output register.
`default_nettype none

module bpc_back import bpc_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cfg_wr_t             cfg,
    input  wire logic                q_empty,
    input  wire q_entry_t            head,
    output logic                     q_pop,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [OutDataW-1:0]      m_tdata,
    output logic                     m_tuser,
    output logic                     m_tlast
);

    back_state_t state_reg, state_next;

    logic [CoordW-1:0] center_col_reg, center_row_reg;
    logic [CountW-1:0] div_reg;
    logic [CountW-1:0] rem_c_reg, rem_r_reg;
    logic [QuotW-1:0]  dq_c_reg, dq_r_reg;
    logic [StepW-1:0]  step_reg;

    logic              m_tvalid_reg;
    logic [PixW-1:0]   blue_reg, green_reg, red_reg;
    logic              det_reg, last_reg, none_reg;
    logic [CountW-1:0] count_reg;
    logic [OffW-1:0]   col_off_reg, row_off_reg;

    logic              can_load, load_out, start_div, fin;
    logic [CountW:0]   trial_c, trial_r, sub_c, sub_r;
    logic              ge_c, ge_r;
    logic [OffW-1:0]   col_off, row_off;

    function automatic logic [OffW-1:0] offset_sat(input logic [QuotW-1:0] q,
                                                   input logic [CoordW-1:0] ctr);
        logic signed [OffW:0] diff;
        diff = $signed({2'b0, q}) - $signed({2'b0, ctr, 4'b0});
        if (diff > 16'sd16383) begin
            return 15'h3FFF;
        end else if (diff < -16'sd16384) begin
            return 15'h4000;
        end
        return diff[OffW-1:0];
    endfunction

    always_comb begin
        can_load   = !m_tvalid_reg || m_tready;
        state_next = state_reg;
        q_pop      = 1'b0;
        load_out   = 1'b0;
        start_div  = 1'b0;
        fin        = 1'b0;

        trial_c = {rem_c_reg, dq_c_reg[QuotW-1]};
        trial_r = {rem_r_reg, dq_r_reg[QuotW-1]};
        ge_c    = trial_c >= {1'b0, div_reg};
        ge_r    = trial_r >= {1'b0, div_reg};
        sub_c   = trial_c - {1'b0, div_reg};
        sub_r   = trial_r - {1'b0, div_reg};
        col_off = offset_sat(dq_c_reg, center_col_reg);
        row_off = offset_sat(dq_r_reg, center_row_reg);

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    if (head.last && head.count != '0) begin
                        start_div  = 1'b1;
                        state_next = ST_DIV;
                    end else if (can_load) begin
                        load_out = 1'b1;
                        q_pop    = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (step_reg == StepW'(DivSteps - 1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (can_load) begin
                    load_out   = 1'b1;
                    fin        = 1'b1;
                    q_pop      = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_tvalid_reg   <= 1'b0;
            center_col_reg <= CenterColReset;
            center_row_reg <= CenterRowReset;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg.en && cfg.idx == CFG_CENTER_COL) begin
                center_col_reg <= cfg.data;
            end
            if (cfg.en && cfg.idx == CFG_CENTER_ROW) begin
                center_row_reg <= cfg.data;
            end
        end
    end

    // quotient < 2^14, so sum >> 10 is already below the count
    always_ff @(posedge aclk) begin
        if (start_div) begin
            div_reg   <= head.count;
            rem_c_reg <= {1'b0, head.col_sum[SumW-1:CoordW]};
            rem_r_reg <= {1'b0, head.row_sum[SumW-1:CoordW]};
            dq_c_reg  <= {head.col_sum[CoordW-1:0], 4'b0};
            dq_r_reg  <= {head.row_sum[CoordW-1:0], 4'b0};
            step_reg  <= '0;
        end else if (state_reg == ST_DIV) begin
            rem_c_reg <= ge_c ? sub_c[CountW-1:0] : trial_c[CountW-1:0];
            rem_r_reg <= ge_r ? sub_r[CountW-1:0] : trial_r[CountW-1:0];
            dq_c_reg  <= {dq_c_reg[QuotW-2:0], ge_c};
            dq_r_reg  <= {dq_r_reg[QuotW-2:0], ge_r};
            step_reg  <= step_reg + StepW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            blue_reg    <= head.blue;
            green_reg   <= head.green;
            red_reg     <= head.red;
            det_reg     <= head.detected;
            last_reg    <= head.last;
            none_reg    <= head.last && !fin;
            count_reg   <= fin ? head.count : '0;
            col_off_reg <= fin ? col_off : '0;
            row_off_reg <= fin ? row_off : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = det_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {4'b0, row_off_reg, col_off_reg, count_reg, none_reg,
                       red_reg, green_reg, blue_reg};

endmodule

`default_nettype wire

>>> rtl/core/blue_pixel_centroid_unit.sv
// Top level of the blue pixel centroid unit.
// Takes one BGR pixel per cycle while s_tready is high and returns one
// result per pixel, in order: detected pixels come out painted pure red
// and flagged on m_tuser. The result of a frame's last pixel (m_tlast) also
// carries the hit count and the column and row centroid offsets from the
// configured center in Q10.4. Pixels pass through a four-entry queue; a
// frame's last pixel with detections holds the back end for load, 14
// restoring divider steps on both centroids side by side, and finish,
// while the queue absorbs up to three more pixels before s_tready drops.
// The user writes configuration through cfg_wr_* while idle; not enforced.
`default_nettype none

module blue_pixel_centroid_unit import bpc_pkg::*; #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CfgIdxW-1:0]   cfg_wr_idx,
    input  wire logic [CfgDataW-1:0]  cfg_wr_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // blue_in, green_in, red_in, pixel_col, pixel_row, zero pad
    input  wire logic [InDataW-1:0]   s_tdata,
    input  wire logic                 s_tlast,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // blue_out, green_out, red_out, none_found, detect_count, col_offset,
    // row_offset, zero pad
    output logic [OutDataW-1:0]       m_tdata,
    // detected
    output logic                      m_tuser,
    output logic                      m_tlast
);

    cfg_wr_t  cfg;
    q_entry_t push_entry, head;
    logic     q_push, q_pop, q_full, q_empty;

    assign cfg.en   = cfg_wr_en;
    assign cfg.idx  = cfg_wr_idx;
    assign cfg.data = cfg_wr_data;

    bpc_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    bpc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .full       (q_full),
        .empty      (q_empty),
        .head       (head)
    );

    bpc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_empty  (q_empty),
        .head     (head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

>>> rtl/core/bpc_checker.sv
// Port-level checks for the blue pixel centroid unit, with bind.
`default_nettype none

module bpc_checker import bpc_pkg::*; (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [OutDataW-1:0] m_tdata,
    input wire logic                m_tuser,
    input wire logic                m_tlast
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_painted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[23:16] == 8'hFF && m_tdata[15:0] == 16'h0)
        else $error("detected pixel not painted red");

    a_summary_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[75:24] == '0)
        else $error("summary fields set on a non-final pixel");

    a_empty_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast && m_tdata[24] |-> m_tdata[75:25] == '0)
        else $error("empty frame reports count or offsets");

endmodule

bind blue_pixel_centroid_unit bpc_checker u_bpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
